>>> rtl/hse_pkg.sv
// Package for the heap sort engine: sizes, controller states, RAM request and status types.
package hse_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;

	typedef enum logic [3:0] {
		ST_LOAD,   // take elements
		ST_B_RD,   // build: read parent
		ST_CUR,    // capture sifted value
		ST_CHK,    // read left child if any
		ST_LW,     // capture left child, read right
		ST_RW,     // pick larger child
		ST_CMP,    // move child up or stop
		ST_END,    // drop held value into hole
		ST_X_RD,   // extract: read root
		ST_X_RE,   // capture root, read heap end
		ST_X_SW,   // root to end, end value to sift
		ST_E_RD,   // emit: read entry
		ST_E_WT    // emit: load result register
	} hse_state_t;

	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       waddr;
		logic signed [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]       raddr;
	} hse_ram_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             dropped;
	} hse_stat_t;

endpackage

>>> rtl/hse_if.sv
// Valid/ready channel interfaces for element beats and result beats.
interface hse_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [hse_pkg::DATA_W-1:0]   value;
	logic                                last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface hse_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [hse_pkg::DATA_W-1:0]   sorted_value;
	logic                                last_res;
	logic                                overflow;

	modport source (output valid, output sorted_value, output last_res, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input last_res, input overflow,
		output ready);
endinterface

>>> rtl/hse_ram.sv
// Generic simple dual-port RAM with registered read data.
module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/hse_ctrl.sv
// Heap sort sequencer: load, heap build, extraction and emission around one RAM.
module hse_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	hse_in_if.sink                            items,
	hse_out_if.source                         results,
	output hse_pkg::hse_ram_req_t             ram_req,
	input  logic signed [hse_pkg::DATA_W-1:0] ram_rdata,
	output hse_pkg::hse_stat_t                stat
);

	hse_pkg::hse_state_t state_q, state_d;

	logic [hse_pkg::CNT_W-1:0]         cnt_q;
	logic                              drop_q;
	logic                              phase_q;   // 0 build, 1 extract
	logic [hse_pkg::IDX_W-1:0]         end_q, nlast_q, par_q, pos_q, bidx_q, eidx_q;
	logic signed [hse_pkg::DATA_W-1:0] cur_q, best_q, root_q;
	logic signed [hse_pkg::DATA_W-1:0] res_val_q;
	logic                              res_vld_q, res_last_q, res_ovf_q;

	logic                              full, take, slot_free, stop, has_l, has_r;
	logic [hse_pkg::CNT_W-1:0]         lchild;
	logic [hse_pkg::IDX_W-1:0]         laddr, nlast_in;

	assign full      = (cnt_q == hse_pkg::CNT_W'(hse_pkg::DEPTH));
	assign take      = items.valid && items.ready;
	assign slot_free = !res_vld_q || results.ready;
	assign lchild    = {pos_q, 1'b1};
	assign laddr     = lchild[hse_pkg::IDX_W-1:0];
	assign has_l     = (lchild <= {1'b0, end_q});
	assign has_r     = (lchild <  {1'b0, end_q});
	assign stop      = (cur_q >= best_q);
	assign nlast_in  = full ? hse_pkg::IDX_W'(hse_pkg::DEPTH - 1) : cnt_q[hse_pkg::IDX_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hse_pkg::ST_LOAD: begin
				if (take && items.last) begin
					state_d = (cnt_q != '0) ? hse_pkg::ST_B_RD : hse_pkg::ST_E_RD;
				end
			end
			hse_pkg::ST_B_RD: state_d = hse_pkg::ST_CUR;
			hse_pkg::ST_CUR:  state_d = hse_pkg::ST_CHK;
			hse_pkg::ST_CHK:  state_d = has_l ? hse_pkg::ST_LW : hse_pkg::ST_END;
			hse_pkg::ST_LW:   state_d = has_r ? hse_pkg::ST_RW : hse_pkg::ST_CMP;
			hse_pkg::ST_RW:   state_d = hse_pkg::ST_CMP;
			hse_pkg::ST_CMP:  state_d = stop ? hse_pkg::ST_END : hse_pkg::ST_CHK;
			hse_pkg::ST_END: begin
				if (!phase_q) begin
					state_d = (par_q == '0) ? hse_pkg::ST_X_RD : hse_pkg::ST_B_RD;
				end else begin
					state_d = (end_q == '0) ? hse_pkg::ST_E_RD : hse_pkg::ST_X_RD;
				end
			end
			hse_pkg::ST_X_RD: state_d = hse_pkg::ST_X_RE;
			hse_pkg::ST_X_RE: state_d = hse_pkg::ST_X_SW;
			hse_pkg::ST_X_SW: state_d = hse_pkg::ST_CHK;
			hse_pkg::ST_E_RD: state_d = slot_free ? hse_pkg::ST_E_WT : hse_pkg::ST_E_RD;
			hse_pkg::ST_E_WT: state_d = (eidx_q == nlast_q) ? hse_pkg::ST_LOAD : hse_pkg::ST_E_RD;
			default:          state_d = hse_pkg::ST_LOAD;
		endcase
	end

	// outputs: RAM port and ready
	always_comb begin
		ram_req       = '0;
		items.ready   = 1'b0;
		case (state_q)
			hse_pkg::ST_LOAD: begin
				items.ready   = 1'b1;
				ram_req.we    = items.valid && !full;
				ram_req.waddr = cnt_q[hse_pkg::IDX_W-1:0];
				ram_req.wdata = items.value;
			end
			hse_pkg::ST_B_RD: ram_req.raddr = par_q;
			hse_pkg::ST_CHK:  ram_req.raddr = laddr;
			hse_pkg::ST_LW:   ram_req.raddr = laddr + 1'b1;
			hse_pkg::ST_CMP: begin
				ram_req.we    = !stop;
				ram_req.waddr = pos_q;
				ram_req.wdata = best_q;
			end
			hse_pkg::ST_END: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q;
				ram_req.wdata = cur_q;
			end
			hse_pkg::ST_X_RE: ram_req.raddr = end_q;
			hse_pkg::ST_X_SW: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = end_q;
				ram_req.wdata = root_q;
			end
			hse_pkg::ST_E_RD: ram_req.raddr = eidx_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hse_pkg::ST_LOAD;
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			phase_q   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (results.valid && results.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				hse_pkg::ST_LOAD: begin
					if (take) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (items.last) begin
							phase_q <= 1'b0;
						end
					end
				end
				hse_pkg::ST_END: begin
					if (!phase_q && par_q == '0) begin
						phase_q <= 1'b1;
					end
				end
				hse_pkg::ST_E_WT: begin
					res_vld_q <= 1'b1;
					if (eidx_q == nlast_q) begin
						cnt_q  <= '0;
						drop_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			hse_pkg::ST_LOAD: begin
				if (take && items.last) begin
					end_q   <= nlast_in;
					nlast_q <= nlast_in;
					par_q   <= nlast_in >> 1;
					eidx_q  <= '0;
				end
			end
			hse_pkg::ST_B_RD: pos_q <= par_q;
			hse_pkg::ST_CUR:  cur_q <= ram_rdata;
			hse_pkg::ST_LW: begin
				best_q <= ram_rdata;
				bidx_q <= laddr;
			end
			hse_pkg::ST_RW: begin
				if (ram_rdata > best_q) begin
					best_q <= ram_rdata;
					bidx_q <= laddr + 1'b1;
				end
			end
			hse_pkg::ST_CMP: begin
				if (!stop) begin
					pos_q <= bidx_q;
				end
			end
			hse_pkg::ST_END: begin
				if (!phase_q && par_q != '0) begin
					par_q <= par_q - 1'b1;
				end
			end
			hse_pkg::ST_X_RE: root_q <= ram_rdata;
			hse_pkg::ST_X_SW: begin
				cur_q <= ram_rdata;
				pos_q <= '0;
				end_q <= end_q - 1'b1;
			end
			hse_pkg::ST_E_WT: begin
				res_val_q  <= ram_rdata;
				res_last_q <= (eidx_q == nlast_q);
				res_ovf_q  <= drop_q;
				eidx_q     <= eidx_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign results.valid        = res_vld_q;
	assign results.sorted_value = res_val_q;
	assign results.last_res     = res_last_q;
	assign results.overflow     = res_ovf_q;

	assign stat.count   = cnt_q;
	assign stat.dropped = drop_q;

endmodule

>>> rtl/heap_sort_engine_top.sv
// Heap sort engine top level: sequencer, element RAM and checks.
// Loading takes one element beat per cycle. After the last beat the sequencer builds the heap
// and extracts in place, sifting each value down level by level; emission then reads each
// entry and loads the result register, holding while the previous result is not taken.
// Throughput: one set at a time; the next set's beats are taken while the final result beat
// still waits. Reset clears count, overflow and control; the element RAM is not cleared.
module heap_sort_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	hse_in_if.sink      items,
	hse_out_if.source   results
);

	hse_pkg::hse_ram_req_t             ram_req;
	logic signed [hse_pkg::DATA_W-1:0] ram_rdata;
	hse_pkg::hse_stat_t                stat;

	// sequencer: owns the FSM, the sift registers and the result register
	hse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.results   (results),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.stat      (stat)
	);

	// element store, heap lives in place
	hse_ram #(
		.WIDTH (hse_pkg::DATA_W),
		.DEPTH (hse_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// fill count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= hse_pkg::CNT_W'(hse_pkg::DEPTH))
		else $error("element count above depth");

	// drop flag only with a full store
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		stat.dropped |-> (stat.count == hse_pkg::CNT_W'(hse_pkg::DEPTH)))
		else $error("drop flag set with store not full");

	// nothing follows the final beat of a run
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.last_res) |=> !results.valid)
		else $error("result beat after end of run");

	// load stays closed while a run is still being emitted
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && !results.last_res) |=> !items.ready)
		else $error("load reopened before run end");

endmodule
